@@ design/multi_ring_work_queue_top_assert.svh @@
// assertion macros for the multi ring work queue checker
`ifndef MULTI_RING_WORK_QUEUE_TOP_ASSERT_SVH
`define MULTI_RING_WORK_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MRWQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define MRWQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mrwq_pkg.sv @@
// types and codes shared by the multi ring work queue modules
package mrwq_pkg;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_QUERY   = 2'd3;

   localparam logic [1:0] KIND_RX  = 2'd0;
   localparam logic [1:0] KIND_TX  = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INACTIVE = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   localparam logic [1:0] HEALTH_OK       = 2'd0;
   localparam logic [1:0] HEALTH_INACTIVE = 2'd1;
   localparam logic [1:0] HEALTH_OVERRUN  = 2'd2;
   localparam logic [1:0] HEALTH_FULL     = 2'd3;

   localparam logic [1:0] SEL_ENQUEUED = 2'd0;
   localparam logic [1:0] SEL_DEQUEUED = 2'd1;
   localparam logic [1:0] SEL_OVERRUN  = 2'd2;
   localparam logic [1:0] SEL_SPURIOUS = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  device;
      logic [1:0]  work_kind;
      logic [15:0] data_short;
      logic [31:0] data_long;
      logic [31:0] buffer_ref;
      logic [1:0]  stat_select;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  out_kind;
      logic [15:0] out_short;
      logic [31:0] out_long;
      logic [31:0] out_ref;
      logic        pending_flag;
      logic        any_pending;
      logic [4:0]  fill_count;
      logic [6:0]  utilization;
      logic [1:0]  health;
      logic [31:0] stat_value;
   } rsp_type;

   // one ring slot
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] short_data;
      logic [31:0] long_data;
      logic [31:0] buf_handle;
   } item_type;

   // per-device wrapping counters
   typedef struct packed {
      logic [31:0] enq;
      logic [31:0] deq;
      logic [31:0] ovr;
      logic [31:0] spur;
   } stat_set_type;

   // memory read issued at the accepting edge
   typedef struct packed {
      logic       en;
      logic [1:0] device;
   } rd_cmd_type;

   // transaction held for the execute cycle
   typedef struct packed {
      logic       commit;
      logic       active;
      logic [1:0] op;
      logic [1:0] device;
      logic [2:0] limit;
      item_type   item;
   } exec_type;

   // ring view of the addressed device: full and empty before the step, pending flags after it
   typedef struct packed {
      logic full;
      logic empty;
      logic pending;
      logic any_pending;
   } ring_status_type;

endpackage

@@ design/mrwq_ring.sv @@
// ring indices, pending flags and the slot memory of all device queues
module mrwq_ring #(
   parameter int QUEUES = 4,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mrwq_pkg::rd_cmd_type     rd_cmd,
   input  mrwq_pkg::exec_type       ex,
   output mrwq_pkg::item_type       rd_item,
   output logic [$clog2(DEPTH)-1:0] fill,
   output mrwq_pkg::ring_status_type ring_st
);

   localparam int IW    = $clog2(DEPTH);
   localparam int DW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int SLOTS = QUEUES * DEPTH;
   localparam int SAW   = $clog2(SLOTS);
   localparam logic [IW-1:0]  LAST_IDX = IW'(DEPTH - 1);
   localparam logic [IW:0]    DEPTH_W  = (IW + 1)'(DEPTH);
   localparam logic [SAW-1:0] DEPTH_A  = SAW'(DEPTH);

   logic [IW-1:0]     wr_idx_ff [QUEUES];
   logic [IW-1:0]     wr_idx_in [QUEUES];
   logic [IW-1:0]     rd_idx_ff [QUEUES];
   logic [IW-1:0]     rd_idx_in [QUEUES];
   logic [QUEUES-1:0] pend_ff;
   logic [QUEUES-1:0] pend_in;

   mrwq_pkg::item_type slot_mem [SLOTS];
   mrwq_pkg::item_type rd_item_ff;
   mrwq_pkg::item_type wr_item;

   logic [DW-1:0]  ex_dev;
   logic [DW-1:0]  rq_dev;
   logic [IW-1:0]  cur_w;
   logic [IW-1:0]  cur_r;
   logic [IW-1:0]  nxt_w;
   logic [IW-1:0]  nxt_r;
   logic [IW-1:0]  new_w;
   logic [IW-1:0]  new_r;
   logic [IW:0]    fill_ext;
   logic           full;
   logic           empty;
   logic           slot_we;
   logic           any_pend;
   logic [SAW-1:0] wr_addr;
   logic [SAW-1:0] rd_addr;

   always_comb begin
      ex_dev = DW'(ex.device);
      rq_dev = DW'(rd_cmd.device);
      cur_w  = wr_idx_ff[ex_dev];
      cur_r  = rd_idx_ff[ex_dev];
      nxt_w  = (cur_w == LAST_IDX) ? '0 : cur_w + 1'b1;
      nxt_r  = (cur_r == LAST_IDX) ? '0 : cur_r + 1'b1;
      full   = (nxt_w == cur_r);
      empty  = (cur_r == cur_w);

      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      pend_in   = pend_ff;
      slot_we   = 1'b0;
      if (ex.commit && ex.active) begin
         case (ex.op)
            mrwq_pkg::OP_ENQUEUE: begin
               pend_in[ex_dev] = 1'b1;
               if (!full) begin
                  slot_we           = 1'b1;
                  wr_idx_in[ex_dev] = nxt_w;
               end
            end
            mrwq_pkg::OP_DEQUEUE: begin
               if (empty) begin
                  pend_in[ex_dev] = 1'b0;
               end else begin
                  rd_idx_in[ex_dev] = nxt_r;
               end
            end
            default: begin
            end
         endcase
      end

      // fill after the step, modulo the ring length
      new_w    = wr_idx_in[ex_dev];
      new_r    = rd_idx_in[ex_dev];
      fill_ext = {1'b0, new_w} - {1'b0, new_r} + ((new_w < new_r) ? DEPTH_W : '0);

      any_pend = 1'b0;
      for (int i = 0; i < QUEUES; i++) begin
         if ((5'(i) < {2'b00, ex.limit}) && pend_in[i]) begin
            any_pend = 1'b1;
         end
      end
   end

   // long word only for error items, buffer handle only for receive items
   always_comb begin
      wr_item            = ex.item;
      wr_item.long_data  = (ex.item.kind == mrwq_pkg::KIND_ERR) ? ex.item.long_data : '0;
      wr_item.buf_handle = (ex.item.kind == mrwq_pkg::KIND_RX) ? ex.item.buf_handle : '0;
   end

   assign wr_addr = SAW'(ex_dev) * DEPTH_A + SAW'(cur_w);
   assign rd_addr = SAW'(rq_dev) * DEPTH_A + SAW'(rd_idx_ff[rq_dev]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUES; i++) begin
            wr_idx_ff[i] <= '0;
            rd_idx_ff[i] <= '0;
         end
         pend_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[wr_addr] <= wr_item;
      end
      if (rd_cmd.en) begin
         rd_item_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_item             = rd_item_ff;
   assign fill                = fill_ext[IW-1:0];
   assign ring_st.full        = full;
   assign ring_st.empty       = empty;
   assign ring_st.pending     = pend_in[ex_dev];
   assign ring_st.any_pending = any_pend;

endmodule

@@ design/mrwq_stats.sv @@
// per-device statistics counters held in a small memory with valid bits
module mrwq_stats #(
   parameter int QUEUES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mrwq_pkg::rd_cmd_type      rd_cmd,
   input  mrwq_pkg::exec_type        ex,
   input  mrwq_pkg::ring_status_type ring_st,
   output mrwq_pkg::stat_set_type    stats
);

   localparam int DW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   mrwq_pkg::stat_set_type cnt_mem [QUEUES];
   mrwq_pkg::stat_set_type rd_q_ff;
   mrwq_pkg::stat_set_type cur;
   mrwq_pkg::stat_set_type nxt;

   logic [QUEUES-1:0] vld_ff;
   logic [QUEUES-1:0] vld_in;
   logic              rd_vld_ff;
   logic              cnt_we;
   logic [DW-1:0]     ex_dev;
   logic [DW-1:0]     rq_dev;

   always_comb begin
      ex_dev = DW'(ex.device);
      rq_dev = DW'(rd_cmd.device);
      // an entry never written since reset reads as zero
      cur    = rd_vld_ff ? rd_q_ff : '0;
      nxt    = cur;
      if (ex.active) begin
         case (ex.op)
            mrwq_pkg::OP_ENQUEUE: begin
               if (ring_st.full) begin
                  nxt.ovr = cur.ovr + 32'd1;
               end else begin
                  nxt.enq = cur.enq + 32'd1;
               end
            end
            mrwq_pkg::OP_DEQUEUE: begin
               if (ring_st.empty) begin
                  nxt.spur = cur.spur + 32'd1;
               end else begin
                  nxt.deq = cur.deq + 32'd1;
               end
            end
            mrwq_pkg::OP_CLEAR: begin
               nxt = '0;
            end
            default: begin
            end
         endcase
      end
      cnt_we = ex.commit && ex.active;
      vld_in = vld_ff;
      if (cnt_we) begin
         vld_in[ex_dev] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_cmd.en) begin
            rd_vld_ff <= vld_ff[rq_dev];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[ex_dev] <= nxt;
      end
      if (rd_cmd.en) begin
         rd_q_ff <= cnt_mem[rq_dev];
      end
   end

   assign stats = nxt;

endmodule

@@ design/multi_ring_work_queue_top.sv @@
// top level of the multi ring work queue: sequencer, result register and csr
// the result is registered when the held transaction commits; the commit waits while an
//   earlier result is stalled, and no new transaction is taken before it; each one reads
//   the slot and counter memories at the accepting edge and writes them back at its commit
// reset: synchronous, clears active_queues, ring indices, pending flags and counter
//   valid bits at once; the slot memory is not cleared and needs no clearing pass
module multi_ring_work_queue_top #(
   parameter int QUEUES = 4,
   parameter int DEPTH  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrwq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrwq_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_write_data
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   // devices beyond the queue count stay inactive whatever active_queues says
   localparam logic [2:0] QUEUE_CAP = (QUEUES > 7) ? 3'd7 : 3'(QUEUES);
   // utilization = fill * 100 / DEPTH through a rounded-up reciprocal, exact for fill < DEPTH
   localparam int UTIL_SH = 22;
   localparam int unsigned UTIL_MUL = (100 * (1 << UTIL_SH) + DEPTH - 1) / DEPTH;
   localparam logic [27:0] UTIL_MUL_W = 28'(UTIL_MUL);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   mrwq_pkg::rsp_type rsp_data_ff;
   mrwq_pkg::rsp_type rsp_data_in;
   mrwq_pkg::req_type req_ff;
   mrwq_pkg::req_type req_in;
   logic [2:0]        active_ff;
   logic [2:0]        active_in;

   logic                      accept;
   logic                      out_free;
   logic                      commit;
   logic [2:0]                limit;
   logic                      act_now;
   logic                      act_held;
   mrwq_pkg::rd_cmd_type      rd_cmd;
   mrwq_pkg::exec_type        ex;
   mrwq_pkg::item_type        rd_item;
   mrwq_pkg::ring_status_type ring_st;
   mrwq_pkg::stat_set_type    stats;
   logic [IW-1:0]             fill;
   logic [IW+27:0]            util_prod;
   mrwq_pkg::rsp_type         result;

   // one transaction in flight; the result register frees the input side
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_EXEC) && out_free;

   // configured queue count, clipped to the number of rings built
   assign limit    = (active_ff > QUEUE_CAP) ? QUEUE_CAP : active_ff;
   assign act_now  = ({1'b0, req_data.device} < limit);
   assign act_held = ({1'b0, req_ff.device} < limit);

   // memory reads go out with the accepting edge, inactive devices read the entries of device zero
   assign rd_cmd.en     = accept;
   assign rd_cmd.device = act_now ? req_data.device : '0;

   // held transaction drives the read-modify-write cycle
   assign ex.commit          = commit;
   assign ex.active          = act_held;
   assign ex.op              = req_ff.op;
   assign ex.device          = req_ff.device;
   assign ex.limit           = limit;
   assign ex.item.kind       = req_ff.work_kind;
   assign ex.item.short_data = req_ff.data_short;
   assign ex.item.long_data  = req_ff.data_long;
   assign ex.item.buf_handle = req_ff.buffer_ref;

   mrwq_ring #(
      .QUEUES (QUEUES),
      .DEPTH  (DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .rd_cmd  (rd_cmd),
      .ex      (ex),
      .rd_item (rd_item),
      .fill    (fill),
      .ring_st (ring_st)
   );

   mrwq_stats #(
      .QUEUES (QUEUES)
   ) u_stats (
      .clock   (clock),
      .reset   (reset),
      .rd_cmd  (rd_cmd),
      .ex      (ex),
      .ring_st (ring_st),
      .stats   (stats)
   );

   assign util_prod = {28'b0, fill} * {{IW{1'b0}}, UTIL_MUL_W};

   // result of the held transaction: post-step fill, pending flags and counters, pre-step full and empty
   always_comb begin
      result             = '0;
      result.any_pending = ring_st.any_pending;
      if (!act_held) begin
         result.status = mrwq_pkg::STATUS_INACTIVE;
         result.health = mrwq_pkg::HEALTH_INACTIVE;
      end else begin
         result.status = mrwq_pkg::STATUS_OK;
         if (req_ff.op == mrwq_pkg::OP_ENQUEUE && ring_st.full) begin
            result.status = mrwq_pkg::STATUS_FULL;
         end
         if (req_ff.op == mrwq_pkg::OP_DEQUEUE) begin
            if (ring_st.empty) begin
               result.status = mrwq_pkg::STATUS_EMPTY;
            end else begin
               // item only on a successful dequeue
               result.out_kind  = rd_item.kind;
               result.out_short = rd_item.short_data;
               result.out_long  = rd_item.long_data;
               result.out_ref   = rd_item.buf_handle;
            end
         end
         result.pending_flag = ring_st.pending;
         result.fill_count   = 5'(fill);
         result.utilization  = util_prod[UTIL_SH+6:UTIL_SH];
         // overrun share wins over a full ring
         if (stats.ovr > (stats.enq >> 2)) begin
            result.health = mrwq_pkg::HEALTH_OVERRUN;
         end else if (fill == LAST_IDX) begin
            result.health = mrwq_pkg::HEALTH_FULL;
         end else begin
            result.health = mrwq_pkg::HEALTH_OK;
         end
         case (req_ff.stat_select)
            mrwq_pkg::SEL_ENQUEUED: result.stat_value = stats.enq;
            mrwq_pkg::SEL_DEQUEUED: result.stat_value = stats.deq;
            mrwq_pkg::SEL_OVERRUN:  result.stat_value = stats.ovr;
            default:                result.stat_value = stats.spur;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here while an earlier result is still stalled
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = commit ? result : rsp_data_ff;
      req_in       = accept ? req_data : req_ff;
      active_in    = csr_write_en ? csr_write_data : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
      end
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/mrwq_checker.sv @@
// port-level checks for the multi ring work queue, bound to the top level
`include "multi_ring_work_queue_top_assert.svh"

module mrwq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mrwq_pkg::rsp_type rsp_data
);

   `MRWQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result transaction changed")
   `MRWQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second transaction accepted while one is in flight")
   `MRWQ_ASSERT_IMPLY(a_inactive_zero, clock, reset, rsp_valid && rsp_data.status == mrwq_pkg::STATUS_INACTIVE, rsp_data.health == mrwq_pkg::HEALTH_INACTIVE && rsp_data.fill_count == 5'd0 && !rsp_data.pending_flag && rsp_data.stat_value == 32'd0, "inactive result carries device state")
   `MRWQ_ASSERT_IMPLY(a_empty_clears, clock, reset, rsp_valid && rsp_data.status == mrwq_pkg::STATUS_EMPTY, !rsp_data.pending_flag && rsp_data.fill_count == 5'd0 && rsp_data.out_kind == 2'd0, "empty dequeue left pending flag, fill or item")
   `MRWQ_ASSERT_IMPLY(a_any_pending, clock, reset, rsp_valid && rsp_data.status != mrwq_pkg::STATUS_INACTIVE && rsp_data.pending_flag, rsp_data.any_pending, "pending device not reflected in any_pending")

endmodule

bind multi_ring_work_queue_top mrwq_checker u_mrwq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
